// ===== sv/sra_pkg.sv =====
// sra_pkg: types, codes and sizes shared by the segment reassembler modules
// no dependencies
`timescale 1ns / 1ps

package sra_pkg;

  localparam int BUFFER_DEPTH = 4096;
  localparam int HEADER_BYTES = 5;
  localparam int BUF_AW = $clog2(BUFFER_DEPTH);
  localparam int LEN_W = BUF_AW + 1;
  localparam int CNT_W = 17;
  localparam int DST_W = CNT_W + 2;
  localparam int IDX_W = 7;
  localparam int HW = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int OQ_DEPTH = 2;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [HW-1:0] MAX_LEN_RESET = 16'd1024;

  localparam logic [0:0] CFG_MAX_LEN = 1'b0;
  localparam logic [0:0] CFG_WORD_ORDER = 1'b1;

  typedef enum logic [1:0] {
    OP_SEG     = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } sra_op_t;

  typedef enum logic [1:0] {
    ST_MORE = 2'd0,
    ST_DONE = 2'd1,
    ST_FAIL = 2'd2,
    ST_READ = 2'd3
  } sra_status_t;

  typedef enum logic [1:0] {
    K_BYTE    = 2'd0,
    K_READ    = 2'd1,
    K_RESTART = 2'd2
  } sra_kind_t;

  typedef enum logic [2:0] {
    F_FLAG    = 3'd0,
    F_OFF_LO  = 3'd1,
    F_OFF_HI  = 3'd2,
    F_LEN_LO  = 3'd3,
    F_LEN_HI  = 3'd4,
    F_PAYLOAD = 3'd5
  } sra_field_t;

  typedef struct packed {
    sra_op_t     op;
    logic [7:0]  data_byte;
    logic        segment_end;
    logic [11:0] read_address;
  } sra_in_t;

  typedef struct packed {
    sra_status_t      status;
    logic [7:0]       read_data;
    logic [LEN_W-1:0] assembled_length;
  } sra_out_t;

  typedef struct packed {
    sra_kind_t        kind;
    sra_field_t       field;
    logic             last;
    logic [7:0]       data;
    logic [11:0]      addr;
    logic [CNT_W-1:0] pay_idx;
    logic [CNT_W-1:0] size;
  } sra_item_t;

endpackage

// ===== sv/sra_front.sv =====
// sra_front: accepts input transfers, tracks the byte position in the segment
// and tags each byte with its header field; depends on sra_pkg
`timescale 1ns / 1ps

module sra_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sra_pkg::sra_in_t   in_item,
  output logic               full,
  input  logic               word_order_big,
  input  logic               q_full,
  output logic               q_push,
  output sra_pkg::sra_item_t q_item
);

  logic [sra_pkg::CNT_W-1:0] bc_r, bc_nxt;
  logic [sra_pkg::CNT_W-1:0] size;
  logic                      accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign size   = (bc_r == sra_pkg::CNT_MAX) ? bc_r : bc_r + 1'b1;

  always_comb begin
    q_item.data    = in_item.data_byte;
    q_item.addr    = in_item.read_address;
    q_item.last    = in_item.segment_end;
    q_item.pay_idx = bc_r - sra_pkg::CNT_W'(sra_pkg::HEADER_BYTES);
    q_item.size    = size;
    priority if (bc_r == sra_pkg::CNT_W'(0)) begin
      q_item.field = sra_pkg::F_FLAG;
    end else if (bc_r == sra_pkg::CNT_W'(1)) begin
      q_item.field = word_order_big ? sra_pkg::F_OFF_HI : sra_pkg::F_OFF_LO;
    end else if (bc_r == sra_pkg::CNT_W'(2)) begin
      q_item.field = word_order_big ? sra_pkg::F_OFF_LO : sra_pkg::F_OFF_HI;
    end else if (bc_r == sra_pkg::CNT_W'(3)) begin
      q_item.field = word_order_big ? sra_pkg::F_LEN_HI : sra_pkg::F_LEN_LO;
    end else if (bc_r == sra_pkg::CNT_W'(4)) begin
      q_item.field = word_order_big ? sra_pkg::F_LEN_LO : sra_pkg::F_LEN_HI;
    end else begin
      q_item.field = sra_pkg::F_PAYLOAD;
    end

    bc_nxt = bc_r;
    q_push = 1'b0;
    q_item.kind = sra_pkg::K_BYTE;
    unique case (in_item.op)
      sra_pkg::OP_SEG: begin
        q_push = accept;
        if (accept) begin
          bc_nxt = in_item.segment_end ? '0 : size;
        end
      end
      sra_pkg::OP_READ: begin
        q_push = accept;
        q_item.kind = sra_pkg::K_READ;
      end
      sra_pkg::OP_RESTART: begin
        q_push = accept;
        q_item.kind = sra_pkg::K_RESTART;
        if (accept) begin
          bc_nxt = '0;
        end
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r <= '0;
    end else begin
      bc_r <= bc_nxt;
    end
  end

endmodule

// ===== sv/sra_queue.sv =====
// sra_queue: short queue of tagged items between front and back
// depends on sra_pkg
`timescale 1ns / 1ps

module sra_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sra_pkg::sra_item_t din,
  output logic               full,
  input  logic               pop,
  output sra_pkg::sra_item_t dout,
  output logic               empty
);

  localparam int AW = $clog2(sra_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(sra_pkg::QUEUE_DEPTH + 1);

  sra_pkg::sra_item_t ent_r [sra_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = cnt_r == CW'(sra_pkg::QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign dout    = ent_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? AW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop ? AW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/sra_back.sv =====
// sra_back: carries out tagged items: header capture, payload buffer,
// segment checks, read-back and the result queue; depends on sra_pkg
`timescale 1ns / 1ps

module sra_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sra_pkg::sra_item_t     item,
  input  logic                   item_valid,
  output logic                   item_pop,
  input  logic [sra_pkg::HW-1:0] max_len,
  output logic                   out_empty,
  input  logic                   out_pop,
  output sra_pkg::sra_out_t      out_item
);

  localparam int AW = sra_pkg::BUF_AW;
  localparam int LW = sra_pkg::LEN_W;
  localparam int DW = sra_pkg::DST_W;
  localparam int OAW = $clog2(sra_pkg::OQ_DEPTH);
  localparam int OCW = $clog2(sra_pkg::OQ_DEPTH + 1);

  logic [7:0] mem [sra_pkg::BUFFER_DEPTH];
  logic [7:0] mem_q_r;

  logic [sra_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [LW-1:0]             off_r, off_nxt;
  logic [7:0]                flag_r, flag_nxt;
  logic [sra_pkg::HW-1:0]    hoff_r, hoff_nxt, hlen_r, hlen_nxt;
  logic                      err_r, err_nxt;

  logic                res_v_r, res_v_nxt;
  sra_pkg::sra_status_t res_st_r, res_st_nxt;
  logic [LW-1:0]       res_len_r, res_len_nxt;
  logic                rd_ok_r, rd_ok_nxt;

  sra_pkg::sra_out_t oq_r [sra_pkg::OQ_DEPTH];
  logic [OAW-1:0]    oq_wp_r, oq_rp_r;
  logic [OCW-1:0]    oq_cnt_r, oq_cnt_nxt;
  sra_pkg::sra_out_t res_out;

  logic          res_go, e_go, fire, we, dst_ok, ok;
  logic [DW-1:0] dst, new_end;
  logic [AW-1:0] waddr, raddr;
  logic          oq_push, oq_pop;

  assign res_go   = oq_cnt_r != OCW'(sra_pkg::OQ_DEPTH);
  assign e_go     = !res_v_r || res_go;
  assign fire     = item_valid && e_go;
  assign item_pop = fire;

  assign dst     = DW'(off_r) + DW'(item.pay_idx);
  assign dst_ok  = dst < DW'(sra_pkg::BUFFER_DEPTH);
  assign waddr   = dst[AW-1:0];
  assign raddr   = AW'(item.addr);

  always_comb begin
    idx_nxt     = idx_r;
    off_nxt     = off_r;
    flag_nxt    = flag_r;
    hoff_nxt    = hoff_r;
    hlen_nxt    = hlen_r;
    err_nxt     = err_r;
    we          = 1'b0;
    ok          = 1'b0;
    new_end     = '0;
    res_v_nxt   = res_v_r;
    res_st_nxt  = res_st_r;
    res_len_nxt = res_len_r;
    rd_ok_nxt   = rd_ok_r;
    if (e_go) begin
      res_v_nxt = 1'b0;
    end
    if (fire) begin
      unique case (item.kind)
        sra_pkg::K_BYTE: begin
          unique case (item.field)
            sra_pkg::F_FLAG:   flag_nxt = item.data;
            sra_pkg::F_OFF_LO: hoff_nxt = {hoff_r[15:8], item.data};
            sra_pkg::F_OFF_HI: hoff_nxt = {item.data, hoff_r[7:0]};
            sra_pkg::F_LEN_LO: hlen_nxt = {hlen_r[15:8], item.data};
            sra_pkg::F_LEN_HI: hlen_nxt = {item.data, hlen_r[7:0]};
            default: begin
              we      = dst_ok;
              err_nxt = err_r || !dst_ok;
            end
          endcase
          if (item.last) begin
            new_end = DW'(off_r) + DW'(hlen_nxt);
            ok = !err_nxt
              && item.size >= sra_pkg::CNT_W'(sra_pkg::HEADER_BYTES)
              && flag_nxt[7:1] == idx_r
              && DW'(hoff_nxt) == DW'(off_r)
              && DW'(hlen_nxt) + DW'(sra_pkg::HEADER_BYTES) == DW'(item.size)
              && DW'(item.size) <= DW'(max_len)
              && new_end <= DW'(sra_pkg::BUFFER_DEPTH);
            if (ok) begin
              idx_nxt    = idx_r + 1'b1;
              off_nxt    = LW'(new_end);
              res_st_nxt = flag_nxt[0] ? sra_pkg::ST_MORE : sra_pkg::ST_DONE;
            end else begin
              res_st_nxt = sra_pkg::ST_FAIL;
            end
            err_nxt     = 1'b0;
            res_v_nxt   = 1'b1;
            rd_ok_nxt   = 1'b0;
            res_len_nxt = off_nxt;
          end
        end
        sra_pkg::K_READ: begin
          res_v_nxt   = 1'b1;
          res_st_nxt  = sra_pkg::ST_READ;
          rd_ok_nxt   = DW'(item.addr) < DW'(off_r);
          res_len_nxt = off_r;
        end
        sra_pkg::K_RESTART: begin
          idx_nxt  = '0;
          off_nxt  = '0;
          flag_nxt = '0;
          hoff_nxt = '0;
          hlen_nxt = '0;
          err_nxt  = 1'b0;
        end
        default: begin
          res_v_nxt = 1'b0;
        end
      endcase
    end
  end

  // payload buffer, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= item.data;
    end
    if (fire) begin
      mem_q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      off_r   <= '0;
      flag_r  <= '0;
      hoff_r  <= '0;
      hlen_r  <= '0;
      err_r   <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      off_r   <= off_nxt;
      flag_r  <= flag_nxt;
      hoff_r  <= hoff_nxt;
      hlen_r  <= hlen_nxt;
      err_r   <= err_nxt;
      res_v_r <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_st_r  <= res_st_nxt;
    res_len_r <= res_len_nxt;
    rd_ok_r   <= rd_ok_nxt;
  end

  // result queue
  assign res_out.status           = res_st_r;
  assign res_out.read_data        = rd_ok_r ? mem_q_r : 8'd0;
  assign res_out.assembled_length = res_len_r;

  assign oq_push   = res_v_r && res_go;
  assign oq_pop    = out_pop && !out_empty;
  assign out_empty = oq_cnt_r == '0;
  assign out_item  = oq_r[oq_rp_r];

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 1'b1;
    end else if (oq_pop && !oq_push) begin
      oq_cnt_nxt = oq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wp_r] <= res_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wp_r <= OAW'(oq_wp_r + 1'b1);
      end
      if (oq_pop) begin
        oq_rp_r <= OAW'(oq_rp_r + 1'b1);
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

endmodule

// ===== sv/segment_reassembler.sv =====
// segment_reassembler: top level, configuration registers and the
// front / queue / back wiring; depends on sra_pkg, sra_front, sra_queue, sra_back
`timescale 1ns / 1ps
//
//  channel   ports                               direction
//  input     push, full, in_item                 in, one per cycle when not full
//  result    empty, pop, out_item                out, one per cycle when not empty
//  config    cfg_we, cfg_index, cfg_wdata        in, write only
//
//  one item per cycle sustained while results are taken; a result crosses the item
//  queue, execute with registered buffer read, result register and result queue
//  rst_n is synchronous; buffer contents are not cleared, reads beyond the
//  committed length return 0
//  a stalled result side fills the 2-entry result queue and the result register,
//  then the 4-entry item queue, then raises full

module segment_reassembler (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  sra_pkg::sra_in_t       in_item,
  output logic                   empty,
  input  logic                   pop,
  output sra_pkg::sra_out_t      out_item,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [sra_pkg::HW-1:0] cfg_wdata
);

  logic [sra_pkg::HW-1:0] max_len_r;
  logic                   big_r;

  logic               q_push, q_full, q_pop, q_empty;
  sra_pkg::sra_item_t q_din, q_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= sra_pkg::MAX_LEN_RESET;
      big_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sra_pkg::CFG_MAX_LEN:    max_len_r <= cfg_wdata;
        sra_pkg::CFG_WORD_ORDER: big_r     <= cfg_wdata[0];
        default:                 big_r     <= big_r;
      endcase
    end
  end

  sra_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .in_item        (in_item),
    .full           (full),
    .word_order_big (big_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_din)
  );

  sra_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  sra_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (q_dout),
    .item_valid (!q_empty),
    .item_pop   (q_pop),
    .max_len    (max_len_r),
    .out_empty  (empty),
    .out_pop    (pop),
    .out_item   (out_item)
  );

  a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_item.assembled_length <= sra_pkg::LEN_W'(sra_pkg::BUFFER_DEPTH))
    else $error("assembled length beyond buffer");

  a_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.status != sra_pkg::ST_READ) |-> out_item.read_data == 8'd0)
    else $error("read data on a segment result");

endmodule
